[src/vnorm_pkg.sv]
// vnorm_pkg: shared types and constants for the vector Euclidean norm block.
// No dependencies; used by vector_euclidean_norm_top and its testbench.
package vnorm_pkg;

    localparam int FIELD_WIDTH = 32;   // element and magnitude field width
    localparam int SUM_WIDTH   = 64;   // Q32.32 sum of squares
    localparam int ROOT_WIDTH  = 32;   // floored root of a 64-bit value

    typedef struct packed {
        logic signed [FIELD_WIDTH-1:0] element;
        logic                          last_element;
    } vnorm_in_t;

    typedef struct packed {
        logic [FIELD_WIDTH-1:0] magnitude;
        logic                   overflowed;
    } vnorm_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_ROOT
    } vnorm_state_t;

endpackage

[src/vector_euclidean_norm_top.sv]
// vector_euclidean_norm_top: streaming Euclidean norm, one element per transfer.
// Depends on vnorm_pkg (payload structs, state enum, widths).
//
//  channel  | ports                 | direction | transfer when
//  ---------+-----------------------+-----------+---------------------------
//  command  | start, busy, cmd      | in        | start && !busy at clk rise
//  result   | done, result          | out       | done high (one cycle)
//
// Sequence: an element that is not last keeps busy high through the square
// and accumulate states, and the block takes a new element only once back in
// idle. A last element then runs the square root, one result bit per cycle
// on the shared 65-bit add/subtract unit, before done.
// Reset: rst_n asynchronous, active low; clears the sum, the saturation flag,
// the sequencer and the done strobe. The result receiver cannot stall; done
// is high for exactly one cycle and the block may take a new command then.
module vector_euclidean_norm_top #(
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  vnorm_pkg::vnorm_in_t   cmd,
    output logic                   done,
    output vnorm_pkg::vnorm_out_t  result
);

    localparam int SW = vnorm_pkg::SUM_WIDTH;
    localparam int PW = 2 * ELEMENT_WIDTH;

    // sequencer
    vnorm_pkg::vnorm_state_t state_reg, state_next;

    // datapath registers
    logic [ELEMENT_WIDTH-1:0] abs_reg,  abs_next;    // |element|
    logic                     last_reg, last_next;
    logic [SW-1:0]            prod_reg, prod_next;   // square, Q32.32
    logic [SW-1:0]            sum_reg,  sum_next;    // running sum, then root remainder
    logic                     sat_reg,  sat_next;
    logic [SW-1:0]            res_reg,  res_next;    // root being built
    logic [SW-1:0]            bit_reg,  bit_next;    // one-hot trial bit
    logic                     done_reg, done_next;
    vnorm_pkg::vnorm_out_t    result_reg, result_next;

    // shared add/subtract unit
    logic          unit_sub;
    logic [SW-1:0] unit_b;
    logic [SW:0]   unit_out;

    logic                     accept;
    logic [ELEMENT_WIDTH-1:0] elem_low;
    logic [PW-1:0]            square;
    logic [SW-1:0]            trial;

    assign accept   = start && !busy;
    assign elem_low = cmd.element[ELEMENT_WIDTH-1:0];
    assign square   = abs_reg * abs_reg;
    assign trial    = res_reg | bit_reg;   // res never overlaps the trial bit

    // operand B selects the square or the trial root; subtract via inverted B
    assign unit_b   = unit_sub ? trial : prod_reg;
    assign unit_out = {1'b0, sum_reg} + {1'b0, unit_b ^ {SW{unit_sub}}}
                      + {{SW{1'b0}}, unit_sub};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            vnorm_pkg::ST_IDLE:
            begin
                if (start)
                    state_next = vnorm_pkg::ST_MUL;
            end
            vnorm_pkg::ST_MUL:
                state_next = vnorm_pkg::ST_ACC;
            vnorm_pkg::ST_ACC:
                state_next = last_reg ? vnorm_pkg::ST_ROOT : vnorm_pkg::ST_IDLE;
            vnorm_pkg::ST_ROOT:
            begin
                if (bit_reg[0])
                    state_next = vnorm_pkg::ST_IDLE;
            end
            default:
                state_next = vnorm_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        busy     = 1'b1;
        unit_sub = 1'b0;
        case (state_reg)
            vnorm_pkg::ST_IDLE: busy     = 1'b0;
            vnorm_pkg::ST_MUL:  unit_sub = 1'b0;
            vnorm_pkg::ST_ACC:  unit_sub = 1'b0;
            vnorm_pkg::ST_ROOT: unit_sub = 1'b1;
            default:            busy     = 1'b0;
        endcase
    end

    // datapath
    always_comb
    begin
        abs_next    = abs_reg;
        last_next   = last_reg;
        prod_next   = prod_reg;
        sum_next    = sum_reg;
        sat_next    = sat_reg;
        res_next    = res_reg;
        bit_next    = bit_reg;
        done_next   = 1'b0;
        result_next = result_reg;

        if (accept)
        begin
            // most negative value maps onto 2^(W-1), still exact in W bits
            abs_next  = elem_low[ELEMENT_WIDTH-1] ? (~elem_low + 1'b1) : elem_low;
            last_next = cmd.last_element;
        end

        case (state_reg)
            vnorm_pkg::ST_MUL:
                prod_next = SW'(square);
            vnorm_pkg::ST_ACC:
            begin
                if (unit_out[SW])
                begin
                    sum_next = {SW{1'b1}};
                    sat_next = 1'b1;
                end
                else
                    sum_next = unit_out[SW-1:0];
                res_next = '0;
                bit_next = {2'b01, {(SW-2){1'b0}}};
            end
            vnorm_pkg::ST_ROOT:
            begin
                // carry out set: remainder >= trial, keep the bit
                if (unit_out[SW])
                begin
                    sum_next = unit_out[SW-1:0];
                    res_next = (res_reg >> 1) | bit_reg;
                end
                else
                    res_next = res_reg >> 1;
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                begin
                    result_next.magnitude  = res_next[vnorm_pkg::ROOT_WIDTH-1:0];
                    result_next.overflowed = sat_reg;
                    done_next              = 1'b1;
                    sum_next               = '0;
                    sat_next               = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vnorm_pkg::ST_IDLE;
            sum_reg   <= '0;
            sat_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sum_reg   <= sum_next;
            sat_reg   <= sat_next;
            done_reg  <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        abs_reg    <= abs_next;
        last_reg   <= last_next;
        prod_reg   <= prod_next;
        res_reg    <= res_next;
        bit_reg    <= bit_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // checks
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done raised while sequencer busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done strobe longer than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("command transfer did not start the sequencer");

    a_root_bit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == vnorm_pkg::ST_ROOT |-> $onehot(bit_reg))
        else $error("square-root trial bit not one-hot");

endmodule

[tb/vector_euclidean_norm_top_tb.sv]
// vector_euclidean_norm_top_tb: self-checking bench for the streaming Euclidean norm block.
// Depends on vnorm_pkg and vector_euclidean_norm_top; a directed table, then random vectors,
// each result checked against an in-bench sum-of-squares and floored-root predictor.
`timescale 1ns / 100ps

module vector_euclidean_norm_top_tb;

    localparam int ELEMENT_WIDTH  = 32;
    localparam int CLK_HALF       = 6;      // 12 ns period
    localparam int RESET_CYCLES   = 7;
    localparam int RANDOM_ITEMS   = 450;
    localparam int DRAIN_CYCLES   = 40;     // watch for stray strobes after the last result
    localparam int STALL_LIMIT    = 1000;   // cycles with no transfer before giving up
    localparam int PRINT_LIMIT    = 30;     // cap on mismatch lines

    // One row of the directed table. Rows with known set carry a result that is
    // obvious by hand; the rest are checked against the predictor.
    typedef struct {
        logic [vnorm_pkg::FIELD_WIDTH-1:0] value;
        logic                              last;
        logic                              known;
        logic [vnorm_pkg::FIELD_WIDTH-1:0] mag;
        logic                              ovf;
    } stim_row_t;

    localparam int DIR_ROWS = 25;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    vnorm_pkg::vnorm_in_t  cmd;
    logic                  done;
    vnorm_pkg::vnorm_out_t result;

    // predictor state
    logic [vnorm_pkg::SUM_WIDTH-1:0] acc_sum;
    logic                            acc_sat;

    // expected norms, oldest first
    vnorm_pkg::vnorm_out_t pending_norms[$];

    int error_count;
    int burst_left;
    int items_sent;
    int idle_cycles;

    stim_row_t dir_rows [DIR_ROWS] = '{
        // single elements: zero, one, most negative, most positive, minus one lsb
        '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 1'b0},
        '{32'h0001_0000, 1'b1, 1'b1, 32'h0001_0000, 1'b0},
        '{32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000, 1'b0},
        '{32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF, 1'b0},
        '{32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0001, 1'b0},
        // 3, -4 -> 5
        '{32'h0003_0000, 1'b0, 1'b0, 32'h0,         1'b0},
        '{32'hFFFC_0000, 1'b1, 1'b1, 32'h0005_0000, 1'b0},
        // four most-negative elements: 4 * 2^62 saturates the sum
        '{32'h8000_0000, 1'b0, 1'b0, 32'h0,         1'b0},
        '{32'h8000_0000, 1'b0, 1'b0, 32'h0,         1'b0},
        '{32'h8000_0000, 1'b0, 1'b0, 32'h0,         1'b0},
        '{32'h8000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1},
        // sum and flag must be clear after the saturated vector
        '{32'h0002_0000, 1'b1, 1'b1, 32'h0002_0000, 1'b0},
        // six mixed-sign elements
        '{32'h0001_8000, 1'b0, 1'b0, 32'h0,         1'b0},
        '{32'hFFFE_4000, 1'b0, 1'b0, 32'h0,         1'b0},
        '{32'h0000_0001, 1'b0, 1'b0, 32'h0,         1'b0},
        '{32'h7FFF_0000, 1'b0, 1'b0, 32'h0,         1'b0},
        '{32'h8001_0000, 1'b0, 1'b0, 32'h0,         1'b0},
        '{32'h0000_C000, 1'b1, 1'b0, 32'h0,         1'b0},
        // three irregular bit patterns
        '{32'h1234_5678, 1'b0, 1'b0, 32'h0,         1'b0},
        '{32'hEDCB_A988, 1'b0, 1'b0, 32'h0,         1'b0},
        '{32'h5555_AAAA, 1'b1, 1'b0, 32'h0,         1'b0},
        // 4 * (2^31-1)^2 is just below 2^64 and a perfect square
        '{32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0,         1'b0},
        '{32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0,         1'b0},
        '{32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0,         1'b0},
        '{32'h7FFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFE, 1'b0}
    };

    vector_euclidean_norm_top #(
        .ELEMENT_WIDTH(ELEMENT_WIDTH)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .done  (done),
        .result(result)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_HALF) clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Exact square of the low ELEMENT_WIDTH bits read as a two's complement value.
    function automatic logic [vnorm_pkg::SUM_WIDTH-1:0] element_square(
        input logic [vnorm_pkg::FIELD_WIDTH-1:0] value);
        logic [vnorm_pkg::SUM_WIDTH-1:0] raw;
        logic [vnorm_pkg::SUM_WIDTH-1:0] mag;
        raw = {32'd0, value} & ((64'd1 << ELEMENT_WIDTH) - 64'd1);
        mag = raw[ELEMENT_WIDTH-1] ? ((64'd1 << ELEMENT_WIDTH) - raw) : raw;
        return mag * mag;
    endfunction

    // Floored square root, one result bit per pass from the top.
    function automatic logic [vnorm_pkg::ROOT_WIDTH-1:0] floor_root(
        input logic [vnorm_pkg::SUM_WIDTH-1:0] n);
        logic [vnorm_pkg::ROOT_WIDTH-1:0] root;
        logic [vnorm_pkg::SUM_WIDTH-1:0]  trial;
        root = '0;
        for (int b = vnorm_pkg::ROOT_WIDTH - 1; b >= 0; b--)
        begin
            trial = {32'd0, root | (32'd1 << b)};
            if (trial * trial <= n)
                root = root | (32'd1 << b);
        end
        return root;
    endfunction

    // Fold one element into the running sum; on a last element give the
    // norm and clear the sum. Returns 1 when a result is due.
    function automatic logic norm_step(input logic [vnorm_pkg::FIELD_WIDTH-1:0] value,
                                       input logic is_last,
                                       output vnorm_pkg::vnorm_out_t norm);
        logic [vnorm_pkg::SUM_WIDTH:0] wide;
        wide = {1'b0, acc_sum} + {1'b0, element_square(value)};
        if (wide[vnorm_pkg::SUM_WIDTH])
        begin
            acc_sum = '1;
            acc_sat = 1'b1;
        end
        else
            acc_sum = wide[vnorm_pkg::SUM_WIDTH-1:0];
        norm.magnitude  = floor_root(acc_sum);
        norm.overflowed = acc_sat;
        if (is_last)
        begin
            acc_sum = '0;
            acc_sat = 1'b0;
        end
        return is_last;
    endfunction

    // ------------------------------------------------------------------
    // Reporting
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Sender: bursts of transfers separated by random gaps
    // ------------------------------------------------------------------

    function automatic logic [vnorm_pkg::FIELD_WIDTH-1:0] random_element();
        logic [vnorm_pkg::FIELD_WIDTH-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = 32'h8000_0000;
            1:       v = 32'h7FFF_FFFF;
            2:       v = 32'h0000_0000;
            3:       v = $urandom_range(0, 255);
            4:       v = -$urandom_range(1, 255);
            5:       v = {{8{1'b0}}, 24'($urandom())};   // mid-size values
            default: v = $urandom();
        endcase
        return v;
    endfunction

    task automatic send_element(input logic [vnorm_pkg::FIELD_WIDTH-1:0] value,
                                input logic is_last, input logic known,
                                input logic [vnorm_pkg::FIELD_WIDTH-1:0] known_mag,
                                input logic known_ovf);
        vnorm_pkg::vnorm_in_t  item;
        vnorm_pkg::vnorm_out_t norm;
        int                    gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 20);
            repeat (gap)
            begin
                @(negedge clk);
                start <= 1'b0;
                // noise while idle
                cmd   <= vnorm_pkg::vnorm_in_t'({$urandom(), 1'($urandom())});
            end
            // mostly short bursts, sometimes a long stretch with no idling
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        item.element      = value;
        item.last_element = is_last;
        @(negedge clk);
        start <= 1'b1;
        cmd   <= item;
        // transfer happens at the first rising edge with busy low
        do
            @(posedge clk);
        while (busy !== 1'b0);
        burst_left--;
        items_sent++;
        if (norm_step(value, is_last, norm))
        begin
            if (known)
            begin
                norm.magnitude  = known_mag;
                norm.overflowed = known_ovf;
            end
            pending_norms.push_back(norm);
        end
    endtask

    // Hold off until every expected result has come back.
    task automatic wait_for_results();
        @(negedge clk);
        start <= 1'b0;
        while (pending_norms.size() != 0)
            @(posedge clk);
        burst_left = 0;
    endtask

    // ------------------------------------------------------------------
    // Result checker: done is a one-cycle strobe, no backpressure
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        vnorm_pkg::vnorm_out_t want;
        if (rst_n)
        begin
            if ($isunknown(done))
                report_mismatch("done strobe (unknown)", 64'(done), 64'd0);
            else if (done)
            begin
                if (pending_norms.size() == 0)
                    report_mismatch("result with none expected", 64'(result), 64'd0);
                else
                begin
                    want = pending_norms.pop_front();
                    if (result.magnitude !== want.magnitude)
                        report_mismatch("magnitude", 64'(result.magnitude), 64'(want.magnitude));
                    if (result.overflowed !== want.overflowed)
                        report_mismatch("overflowed", 64'(result.overflowed),
                                        64'(want.overflowed));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: counts cycles with neither an input nor a result transfer
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (!rst_n || (start && busy === 1'b0) || done === 1'b1)
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        int vec_len;
        int kind;
        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = '0;
        acc_sum     = '0;
        acc_sat     = 1'b0;
        error_count = 0;
        burst_left  = 0;
        items_sent  = 0;
        idle_cycles = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table
        for (int r = 0; r < DIR_ROWS; r++)
            send_element(dir_rows[r].value, dir_rows[r].last, dir_rows[r].known,
                         dir_rows[r].mag, dir_rows[r].ovf);
        wait_for_results();

        // random vectors: mostly short, some single-element, some long and
        // large enough to saturate the sum
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 9);
            if (kind == 0)
                vec_len = $urandom_range(10, 20);
            else if (kind == 1)
                vec_len = 1;
            else
                vec_len = $urandom_range(2, 8);
            for (int k = 0; k < vec_len; k++)
            begin
                if (kind == 0 && $urandom_range(0, 1) == 1)
                    send_element({1'b1, 31'($urandom())}, k == vec_len - 1, 1'b0, '0, 1'b0);
                else
                    send_element(random_element(), k == vec_len - 1, 1'b0, '0, 1'b0);
            end
            // one mid-run pause until the block has fully drained
            if (items_sent >= RANDOM_ITEMS / 2 && items_sent < RANDOM_ITEMS / 2 + vec_len)
                wait_for_results();
        end

        // drain, then watch a while longer for stray strobes
        @(negedge clk);
        start <= 1'b0;
        while (pending_norms.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
